### hdl/spq_pkg.sv
`default_nettype none
package spq_pkg;

    localparam int PRIO_WIDTH = 3;
    localparam int FIELD_WIDTH = 32;
    localparam int OCC_WIDTH = 5;
    localparam logic [PRIO_WIDTH-1:0] MAX_PRIORITY = 3'd5;

    localparam logic FUNC_ENQ = 1'b0;
    localparam logic FUNC_DEQ = 1'b1;

    typedef logic [PRIO_WIDTH-1:0] t_prio;

    typedef enum logic [2:0] {
        ST_ENQUEUED = 3'd0,
        ST_DEQUEUED = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_REJECTED = 3'd4
    } t_status;

    typedef struct packed {
        logic                          func;
        logic signed [FIELD_WIDTH-1:0] item_value;
        t_prio                         item_priority;
    } t_cmd;

    typedef struct packed {
        t_status                       status;
        logic signed [FIELD_WIDTH-1:0] out_value;
        logic [OCC_WIDTH-1:0]          occupancy;
    } t_rsp;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic  enq;
        logic  deq;
        t_prio prio;
    } t_cell_ctl;

endpackage
`default_nettype wire

### hdl/spq_stream_if.sv
`default_nettype none
interface spq_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hdl/spq_cell.sv
`default_nettype none
module spq_cell
    import spq_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                  i_clk,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_new_value,
    input  wire logic                  i_valid,
    input  wire logic                  i_prev_keep,
    input  wire t_prio                 i_prev_prio,
    input  wire logic [DATA_WIDTH-1:0] i_prev_value,
    input  wire t_prio                 i_next_prio,
    input  wire logic [DATA_WIDTH-1:0] i_next_value,
    output logic                       o_keep,
    output t_prio                      o_prio,
    output logic [DATA_WIDTH-1:0]      o_value
);

    t_prio                 r_prio, n_prio;
    logic [DATA_WIDTH-1:0] r_value, n_value;

    // an entry with lower or equal priority stays ahead of the new one
    assign o_keep = i_valid && (r_prio <= i_ctl.prio);

    always_comb begin
        n_prio  = r_prio;
        n_value = r_value;
        if (i_ctl.enq) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_prio  = i_ctl.prio;
                    n_value = i_new_value;
                end else begin
                    n_prio  = i_prev_prio;
                    n_value = i_prev_value;
                end
            end
        end else if (i_ctl.deq) begin
            n_prio  = i_next_prio;
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prio  <= n_prio;
        r_value <= n_value;
    end

    assign o_prio  = r_prio;
    assign o_value = r_value;

endmodule
`default_nettype wire

### hdl/spq_chain.sv
`default_nettype none
module spq_chain
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32,
    parameter int CW         = $clog2(CAPACITY + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cell_ctl             i_ctl,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    output logic [CW-1:0]              o_count,
    output logic [DATA_WIDTH-1:0]      o_head_value
);

    logic [CW-1:0]         r_count, n_count;
    logic                  w_keep  [CAPACITY];
    t_prio                 w_prio  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_value [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  w_valid;
        logic                  w_prev_keep;
        t_prio                 w_prev_prio, w_next_prio;
        logic [DATA_WIDTH-1:0] w_prev_value, w_next_value;

        assign w_valid = CW'(i) < r_count;

        if (i == 0) begin : g_first
            assign w_prev_keep  = 1'b1;
            assign w_prev_prio  = '0;
            assign w_prev_value = '0;
        end else begin : g_mid
            assign w_prev_keep  = w_keep[i-1];
            assign w_prev_prio  = w_prio[i-1];
            assign w_prev_value = w_value[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign w_next_prio  = '0;
            assign w_next_value = '0;
        end else begin : g_inner
            assign w_next_prio  = w_prio[i+1];
            assign w_next_value = w_value[i+1];
        end

        spq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (i_ctl),
            .i_new_value  (i_value),
            .i_valid      (w_valid),
            .i_prev_keep  (w_prev_keep),
            .i_prev_prio  (w_prev_prio),
            .i_prev_value (w_prev_value),
            .i_next_prio  (w_next_prio),
            .i_next_value (w_next_value),
            .o_keep       (w_keep[i]),
            .o_prio       (w_prio[i]),
            .o_value      (w_value[i])
        );
    end

    always_comb begin
        n_count = r_count;
        if (i_ctl.enq) begin
            n_count = r_count + CW'(1);
        end else if (i_ctl.deq) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count      = r_count;
    assign o_head_value = w_value[0];

endmodule
`default_nettype wire

### hdl/stable_priority_queue.sv
// Channel  Dir  Payload                              Role
// i_cmd    in   func, item_value, item_priority      enqueue / dequeue command
// o_rsp    out  status, out_value, occupancy         one response per command
//
// Every cell of the shift chain decides keep / take-new / take-neighbor in
// parallel, so one transaction per clock unless the output register stalls.
// The response sits in an output register; a new command is taken while that
// register is empty or being drained in the same cycle.
// Synchronous active-low reset empties the queue and the output register.
// Entry storage has no reset; only slots below the count are ever read.
`default_nettype none
module stable_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY   = 16,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    spq_stream_if.sink   i_cmd,
    spq_stream_if.source o_rsp
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                  w_accept;
    logic                  w_is_enq;
    logic [CW-1:0]         w_count;
    logic [CW-1:0]         w_occ_next;
    logic [31:0]           w_occ_ext;
    logic [63:0]           w_in_ext;
    logic [63:0]           w_head_ext;
    logic [DATA_WIDTH-1:0] w_in_data;
    logic [DATA_WIDTH-1:0] w_head_value;
    t_status               w_status;
    t_cell_ctl             w_ctl;
    t_cmd                  w_cmd;

    logic r_out_valid;
    t_rsp r_rsp, n_rsp;

    assign w_cmd        = i_cmd.payload;
    assign i_cmd.ready  = !r_out_valid || o_rsp.ready;
    assign w_accept     = i_cmd.valid && i_cmd.ready;
    assign w_is_enq     = (w_cmd.func == FUNC_ENQ);

    assign w_in_ext  = 64'(unsigned'(w_cmd.item_value));
    assign w_in_data = w_in_ext[DATA_WIDTH-1:0];

    always_comb begin
        if (w_is_enq) begin
            if (w_cmd.item_priority > MAX_PRIORITY) begin
                w_status = ST_REJECTED;
            end else if (w_count == CW'(CAPACITY)) begin
                w_status = ST_FULL;
            end else begin
                w_status = ST_ENQUEUED;
            end
        end else begin
            w_status = (w_count == '0) ? ST_EMPTY : ST_DEQUEUED;
        end
    end

    assign w_ctl.enq  = w_accept && (w_status == ST_ENQUEUED);
    assign w_ctl.deq  = w_accept && (w_status == ST_DEQUEUED);
    assign w_ctl.prio = w_cmd.item_priority;

    spq_chain #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .CW         (CW)
    ) u_chain (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_value      (w_in_data),
        .o_count      (w_count),
        .o_head_value (w_head_value)
    );

    always_comb begin
        w_occ_next = w_count;
        if (w_status == ST_ENQUEUED) begin
            w_occ_next = w_count + CW'(1);
        end else if (w_status == ST_DEQUEUED) begin
            w_occ_next = w_count - CW'(1);
        end
    end

    assign w_occ_ext  = 32'(w_occ_next);
    assign w_head_ext = 64'(w_head_value);

    always_comb begin
        n_rsp.status    = w_status;
        n_rsp.occupancy = w_occ_ext[OCC_WIDTH-1:0];
        n_rsp.out_value = (w_status == ST_DEQUEUED) ? signed'(w_head_ext[FIELD_WIDTH-1:0])
                                                    : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_rsp;

endmodule
`default_nettype wire

### hdl/spq_checker.sv
`default_nettype none
module spq_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_cmd_valid,
    input wire logic i_cmd_ready,
    input wire t_cmd i_cmd_payload,
    input wire logic i_rsp_valid,
    input wire logic i_rsp_ready,
    input wire t_rsp i_rsp_payload
);

    logic w_cmd_xfer;
    assign w_cmd_xfer = i_cmd_valid && i_cmd_ready;

    // out-of-range priority is always rejected, whatever the fill level
    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_xfer && (i_cmd_payload.func == FUNC_ENQ) &&
        (i_cmd_payload.item_priority > MAX_PRIORITY)
        |=> i_rsp_valid && (i_rsp_payload.status == ST_REJECTED))
        else $error("bad priority not rejected");

    a_deq_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_xfer && (i_cmd_payload.func == FUNC_DEQ)
        |=> i_rsp_valid && ((i_rsp_payload.status == ST_DEQUEUED) ||
                            (i_rsp_payload.status == ST_EMPTY)))
        else $error("dequeue gave an enqueue status");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_payload.status != ST_DEQUEUED)
        |-> (i_rsp_payload.out_value == '0))
        else $error("nonzero data without dequeue");

    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (CAPACITY < 32)
        |-> (32'(i_rsp_payload.occupancy) <= 32'(CAPACITY)))
        else $error("occupancy above capacity");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready
        |=> i_rsp_valid && $stable(i_rsp_payload))
        else $error("stalled response changed");

endmodule

bind stable_priority_queue spq_checker #(
    .CAPACITY (CAPACITY)
) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cmd_valid   (i_cmd.valid),
    .i_cmd_ready   (i_cmd.ready),
    .i_cmd_payload (i_cmd.payload),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);
`default_nettype wire

### test/spq_order_checker.sv
module spq_order_checker
    import spq_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    input  wire logic i_cmd_ready,
    input  t_cmd      i_cmd,
    input  wire logic i_rsp_valid,
    input  wire logic i_rsp_ready,
    input  t_rsp      i_rsp,
    output int        o_pending,
    output int        o_checked,
    output int        o_fail_count
);

    // shadow copy of the sorted queue, head at index 0
    logic signed [FIELD_WIDTH-1:0] shadow_val [CAPACITY];
    t_prio                         shadow_prio[CAPACITY];
    int                            shadow_count;

    t_rsp awaited_rsp[$];
    t_rsp want;
    int   mismatch_total;
    int   checked_total;

    assign o_fail_count = mismatch_total;
    assign o_checked    = checked_total;

    function automatic t_rsp queue_apply(input t_cmd c);
        t_rsp r;
        int   pos;
        r.status    = ST_ENQUEUED;
        r.out_value = '0;
        if (c.func == FUNC_ENQ) begin
            if (c.item_priority > MAX_PRIORITY) begin
                r.status = ST_REJECTED;
            end else if (shadow_count >= CAPACITY) begin
                r.status = ST_FULL;
            end else begin
                // new entry goes behind every entry of lower or equal priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] <= c.item_priority)
                    pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_val[k]  = shadow_val[k-1];
                    shadow_prio[k] = shadow_prio[k-1];
                end
                shadow_val[pos]  = c.item_value;
                shadow_prio[pos] = c.item_priority;
                shadow_count++;
                r.status = ST_ENQUEUED;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.out_value = shadow_val[0];
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_val[k-1]  = shadow_val[k];
                    shadow_prio[k-1] = shadow_prio[k];
                end
                shadow_count--;
                r.status = ST_DEQUEUED;
            end
        end
        r.occupancy = shadow_count[OCC_WIDTH-1:0];
        return r;
    endfunction

    initial begin
        mismatch_total = 0;
        checked_total  = 0;
        shadow_count   = 0;
        o_pending      = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            awaited_rsp.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (awaited_rsp.size() == 0) begin
                    $display("%0t: response with no command outstanding: status %0d value %0d occ %0d",
                             $time, i_rsp.status, i_rsp.out_value, i_rsp.occupancy);
                    mismatch_total++;
                end else begin
                    want = awaited_rsp.pop_front();
                    checked_total++;
                    if (i_rsp.status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_rsp.status);
                        mismatch_total++;
                    end
                    if (i_rsp.out_value !== want.out_value) begin
                        $display("%0t: out_value expected %0d actual %0d",
                                 $time, want.out_value, i_rsp.out_value);
                        mismatch_total++;
                    end
                    if (i_rsp.occupancy !== want.occupancy) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occupancy, i_rsp.occupancy);
                        mismatch_total++;
                    end
                end
            end
            // a response never leaves in the cycle its command enters
            if (i_cmd_valid && i_cmd_ready)
                awaited_rsp.push_back(queue_apply(i_cmd));
        end
        o_pending <= awaited_rsp.size();
    end

endmodule

### test/testbench.sv
module testbench;
    import spq_pkg::*;

    localparam int CAPACITY    = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 467;

    logic clk = 1'b0;
    logic rst_n;

    spq_stream_if #(.T(t_cmd)) cmd_if ();
    spq_stream_if #(.T(t_rsp)) rsp_if ();

    int pending;
    int checked;
    int fail_count;
    int cycles = 0;
    int src_gap_pct;
    int snk_stall_pct;
    int enq_sent;
    int deq_sent;

    logic [31:0] dir_val[16] = '{
        32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
        32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 32'hFFFF_FFFE,
        32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678, 32'h8765_4321,
        32'h3C3C_3C3C, 32'hC3C3_C3C3, 32'h00FF_00FF, 32'hFF00_FF00
    };
    t_prio dir_pri[16] = '{
        3'd5, 3'd0, 3'd3, 3'd3, 3'd1, 3'd2, 3'd5, 3'd0,
        3'd4, 3'd3, 3'd2, 3'd1, 3'd0, 3'd5, 3'd4, 3'd3
    };

    stable_priority_queue #(
        .CAPACITY  (CAPACITY),
        .DATA_WIDTH(32)
    ) DUT (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_cmd  (cmd_if),
        .o_rsp  (rsp_if)
    );

    spq_order_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cmd_valid (cmd_if.valid),
        .i_cmd_ready (cmd_if.ready),
        .i_cmd       (cmd_if.payload),
        .i_rsp_valid (rsp_if.valid),
        .i_rsp_ready (rsp_if.ready),
        .i_rsp       (rsp_if.payload),
        .o_pending   (pending),
        .o_checked   (checked),
        .o_fail_count(fail_count)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
            rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // returns at the edge that accepted the transaction, valid still high
    task automatic send_cmd(input logic f, input logic [31:0] v, input t_prio p);
        t_cmd c;
        c.func          = f;
        c.item_value    = v;
        c.item_priority = p;
        while ($urandom_range(99) < src_gap_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_if.valid   <= 1'b1;
        cmd_if.payload <= c;
        if (f == FUNC_ENQ) enq_sent++;
        else deq_sent++;
        @(posedge clk);
        while (!cmd_if.ready) @(posedge clk);
    endtask

    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic random_traffic(input int n);
        int          burst_left;
        int          enq_bias;
        int          prio_lo;
        int          prio_hi;
        logic        f;
        logic [31:0] v;
        t_prio       p;
        burst_left = 0;
        enq_bias   = 50;
        prio_lo    = 0;
        prio_hi    = 5;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2)
                wait_drained();
            // bursts lean toward filling, draining or churning the queue
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 60);
                case ($urandom_range(2))
                    0: enq_bias = 85;
                    1: enq_bias = 15;
                    default: enq_bias = 50;
                endcase
                prio_lo = $urandom_range(0, 5);
                prio_hi = $urandom_range(prio_lo, 5);
            end
            burst_left--;
            f = ($urandom_range(99) < enq_bias) ? FUNC_ENQ : FUNC_DEQ;
            if ($urandom_range(99) < 10) begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end else begin
                v = $urandom;
            end
            if ($urandom_range(99) < 8)
                p = t_prio'($urandom_range(6, 7));
            else
                p = t_prio'($urandom_range(prio_lo, prio_hi));
            send_cmd(f, v, p);
        end
        wait_drained();
    endtask

    initial begin
        rst_n          = 1'b0;
        cmd_if.valid   = 1'b0;
        cmd_if.payload = '0;
        rsp_if.ready   = 1'b0;
        enq_sent       = 0;
        deq_sent       = 0;
        src_gap_pct    = 29;
        snk_stall_pct  = 88;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty dequeue, then rejected priorities on an empty queue
        send_cmd(FUNC_DEQ, 32'h0, 3'd0);
        send_cmd(FUNC_ENQ, 32'h1234_5678, 3'd6);
        send_cmd(FUNC_ENQ, 32'hFFFF_FFFF, 3'd7);
        for (int i = 0; i < CAPACITY; i++)
            send_cmd(FUNC_ENQ, dir_val[i], dir_pri[i]);
        // full drop, and the priority check winning over the full check
        send_cmd(FUNC_ENQ, 32'hDEAD_BEEF, 3'd4);
        send_cmd(FUNC_ENQ, 32'hDEAD_BEEF, 3'd6);
        repeat (4) send_cmd(FUNC_DEQ, 32'h0, 3'd0);
        wait_drained();

        random_traffic(PHASE_ITEMS);

        src_gap_pct   = 88;
        snk_stall_pct = 29;
        random_traffic(PHASE_ITEMS);

        src_gap_pct   = 0;
        snk_stall_pct = 0;
        random_traffic(PHASE_ITEMS);

        repeat (8) @(posedge clk);
        $display("Sent %0d commands (%0d enqueue, %0d dequeue), %0d responses compared.",
                 enq_sent + deq_sent, enq_sent, deq_sent, checked);
        $display("Traffic ran under source-heavy, sink-heavy and no backpressure.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### files.f
hdl/spq_pkg.sv
hdl/spq_stream_if.sv
hdl/spq_cell.sv
hdl/spq_chain.sv
hdl/stable_priority_queue.sv
hdl/spq_checker.sv
test/spq_order_checker.sv
test/testbench.sv
